[design/sli_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted list insert package
// Shared request, response and control types and codes for the sorted list
// insertion core and its storage cells.
// ----------------------------------------------------------------------------
package sli_pkg;

   // Request actions.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value;
      logic [5:0]         index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         position;
      logic signed [31:0] read_value;
      logic [6:0]         count;
   } rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic               insert_en;
      logic signed [31:0] value;
      logic [5:0]         rd_index;
   } cell_ctrl_type;

   // Shared by neighboring cells.
   typedef struct packed {
      logic               greater;
      logic signed [31:0] entry;
      logic signed [31:0] rd;
   } cell_link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

[design/sli_cell.sv]
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one list entry, compares it against the broadcast value, shifts up on
// insert and carries the read chain one step toward the tail.
// ----------------------------------------------------------------------------
module sli_cell #(
   parameter int LOC = 0,
   parameter int UW  = 7
) (
   input  logic                  clock,
   input  sli_pkg::cell_ctrl_type ctrl,
   input  logic [UW-1:0]         used,
   input  sli_pkg::cell_link_type left,
   output sli_pkg::cell_link_type right,
   output logic                  boundary
);

   logic signed [31:0] entry_ff, entry_in;
   logic signed [31:0] rd_ff, rd_in;
   logic               occupied, at_end, greater, hit;

   always_comb begin
      occupied = used > UW'(LOC);
      at_end   = used == UW'(LOC);
      greater  = occupied && (entry_ff > ctrl.value);
      // The new value lands in the first cell that is greater, or at the end.
      boundary = !left.greater && (greater || at_end);
      hit      = 32'(ctrl.rd_index) == 32'(LOC);

      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (left.greater) begin
            entry_in = left.entry;
         end else if (boundary) begin
            entry_in = ctrl.value;
         end
      end
      rd_in = hit ? entry_ff : left.rd;

      right.greater = greater;
      right.entry   = entry_ff;
      right.rd      = rd_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rd_ff    <= rd_in;
   end

endmodule

[design/sorted_list_insert_core.sv]
// ----------------------------------------------------------------------------
// Sorted list insert core
// Ascending list of signed 32-bit values kept in a row of shifting cells,
// with insert, read by index and clear requests.
// ----------------------------------------------------------------------------
// Usage: a request enters on req_valid/req_stall with req_payload; every
// request yields exactly one response on rsp_valid/rsp_stall in rsp_payload.
// An insert is compared in all cells at once; each cell whose left neighbor
// is greater takes that neighbor's value, and the first greater cell (or the
// first free one) takes the new value. Insert, clear and unused actions
// finish in the accept cycle; the response is registered and shows in the
// next cycle, when another such request can follow unless rsp_stall is high.
// A read walks a result chain through the cells, one cell per cycle, through
// the WALK and FINISH states before its response is registered; the length
// of the cell row sets how long the walk lasts.
// Reset empties the list; the stored words themselves are not cleared and
// are never visible, since only entries below the length can be read.
// The response sits in an output register. While the receiver stalls, the
// core still works on a read in flight but accepts no new request until the
// waiting response is taken.
// ----------------------------------------------------------------------------
module sorted_list_insert_core #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sli_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sli_pkg::rsp_type rsp_payload
);

   localparam int UW = $clog2(DEPTH + 1);
   localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   sli_pkg::state_type     state_ff, state_in;
   logic [UW-1:0]          used_ff, used_in;
   logic [CW-1:0]          walk_ff, walk_in;
   logic [5:0]             idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sli_pkg::rsp_type       rsp_ff, rsp_in;

   sli_pkg::cell_ctrl_type ctrl;
   sli_pkg::cell_link_type link [DEPTH+1];
   logic                   bnd [DEPTH];
   logic [CW-1:0]          pos_enc;
   logic                   accept, rsp_free, full, rd_ok;

   // The head of the chain sees an empty neighbor.
   assign link[0] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      sli_cell #(
         .LOC (g),
         .UW  (UW)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .used     (used_ff),
         .left     (link[g]),
         .right    (link[g+1]),
         .boundary (bnd[g])
      );
   end

   // At most one cell flags the landing place of an insert; one does unless full.
   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (bnd[i]) begin
            pos_enc = pos_enc | CW'(i);
         end
      end
   end

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != sli_pkg::ST_IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;
   assign full      = used_ff == UW'(DEPTH);
   assign rd_ok     = 32'(idx_ff) < 32'(used_ff);

   always_comb begin
      ctrl.value     = req_payload.value;
      ctrl.rd_index  = idx_ff;
      ctrl.insert_en = 1'b0;

      state_in     = state_ff;
      used_in      = used_ff;
      walk_in      = walk_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         sli_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in            = '0;
               rsp_in.count      = 7'(used_ff);
               rsp_valid_in      = 1'b1;
               unique case (req_payload.action)
                  sli_pkg::ACT_INSERT: begin
                     if (full) begin
                        rsp_in.status = sli_pkg::ST_FULL;
                     end else begin
                        ctrl.insert_en  = 1'b1;
                        used_in         = used_ff + UW'(1);
                        rsp_in.position = 6'(pos_enc);
                        rsp_in.count    = 7'(used_in);
                     end
                  end
                  sli_pkg::ACT_READ: begin
                     // The response is issued once the read chain settles.
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                     rsp_in       = rsp_ff;
                     idx_in       = req_payload.index;
                     walk_in      = '0;
                     state_in     = sli_pkg::ST_WALK;
                  end
                  sli_pkg::ACT_CLEAR: begin
                     used_in      = '0;
                     rsp_in.count = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sli_pkg::ST_WALK: begin
            // Each cycle the read chain advances one cell toward the tail.
            walk_in = walk_ff + CW'(1);
            if (walk_ff == CW'(DEPTH - 1)) begin
               state_in = sli_pkg::ST_FINISH;
            end
         end
         sli_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_in            = '0;
               rsp_in.count      = 7'(used_ff);
               rsp_valid_in      = 1'b1;
               if (rd_ok) begin
                  rsp_in.read_value = link[DEPTH].rd;
               end else begin
                  rsp_in.status = sli_pkg::ST_RANGE;
               end
               state_in = sli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sli_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sli_pkg::ST_IDLE;
         used_ff      <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
